/* rtl/core/indexed_list_store_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list store.
// Each macro takes a label, an antecedent, a consequent and a message.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH
`ifndef SYNTHESIS
`define ILS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ILS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ILS_ASSERT_IMP(lbl, ante, cons, msg)
`define ILS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg
// Types and constants shared by the indexed list store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

    localparam int DEPTH = 64;
    localparam int WIDTH = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;

    typedef enum logic [2:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_RETRIEVE = 3'd2,
        CMD_REPLACE  = 3'd3,
        CMD_CLEAR    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_RSP
    } t_state;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  position;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [6:0]  count;
        logic        is_full;
        logic        is_empty;
    } t_rsp;

    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [WIDTH-1:0] wdata;
        logic [AW-1:0]    raddr;
    } t_mem_req;

endpackage

`default_nettype wire

/* rtl/core/ils_ram.sv */
// ----------------------------------------------------------------------------
// ils_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ils_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/ils_ctrl.sv */
// ----------------------------------------------------------------------------
// ils_ctrl
// Command sequencer: range checks, entry count, and one address stepper
// that walks the store for shifts, reads and writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_list_store_assert.svh"

module ils_ctrl import ils_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    input  wire t_req             i_req,
    output logic                  o_busy,
    output t_mem_req              o_mem,
    input  wire logic [WIDTH-1:0] i_rdata,
    output logic                  o_rsp_valid,
    output t_rsp                  o_rsp,
    input  wire logic             i_rsp_ready
);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [2:0]       r_cmd, n_cmd;
    logic [AW-1:0]    r_pos, n_pos;
    logic [WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]    r_cur, n_cur;
    logic [AW-1:0]    r_end, n_end;
    logic             r_issue, n_issue;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_paddr, n_paddr;
    logic [WIDTH-1:0] r_out, n_out;
    t_status          r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_issue <= n_issue;
            r_pend  <= n_pend;
        end
        r_cmd    <= n_cmd;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_cur    <= n_cur;
        r_end    <= n_end;
        r_paddr  <= n_paddr;
        r_out    <= n_out;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_val    = r_val;
        n_cur    = r_cur;
        n_end    = r_end;
        n_issue  = r_issue;
        n_pend   = 1'b0;
        n_paddr  = r_paddr;
        n_out    = r_out;
        n_status = r_status;
        o_mem.we    = 1'b0;
        o_mem.waddr = r_pos;
        o_mem.wdata = r_val;
        o_mem.raddr = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_cmd    = i_req.command;
                    n_pos    = i_req.position[AW-1:0];
                    n_val    = i_req.value_in[WIDTH-1:0];
                    n_cur    = i_req.position[AW-1:0];
                    n_end    = i_req.position[AW-1:0];
                    n_out    = '0;
                    n_status = ST_OK;
                    n_issue  = 1'b0;
                    n_state  = S_RSP;
                    unique case (i_req.command)
                        CMD_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (i_req.position > r_count) begin
                                n_status = ST_RANGE;
                            end else begin
                                // walk down from the last entry to the slot
                                n_issue = (i_req.position != r_count);
                                n_cur   = AW'(r_count - 1'b1);
                                n_state = S_INS;
                            end
                        end
                        CMD_DELETE, CMD_RETRIEVE: begin
                            if (i_req.position >= r_count) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_issue = 1'b1;
                                if (i_req.command == CMD_DELETE) begin
                                    n_end = AW'(r_count - 1'b1);
                                end
                                n_state = S_DEL;
                            end
                        end
                        CMD_REPLACE: begin
                            if (i_req.position >= r_count) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_INS;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                // read ahead at r_cur, write the previous read one slot up
                if (r_issue) begin
                    n_pend  = 1'b1;
                    n_paddr = r_cur;
                    if (r_cur == r_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_cur = r_cur - 1'b1;
                    end
                end
                if (r_pend) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_paddr + 1'b1;
                    o_mem.wdata = i_rdata;
                end else if (!r_issue) begin
                    o_mem.we = 1'b1;
                    if (r_cmd == CMD_INSERT) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_RSP;
                end
            end
            S_DEL: begin
                // first read is the entry itself; the rest move one slot down
                if (r_issue) begin
                    n_pend  = 1'b1;
                    n_paddr = r_cur;
                    if (r_cur == r_end) begin
                        n_issue = 1'b0;
                    end else begin
                        n_cur = r_cur + 1'b1;
                    end
                end
                if (r_pend) begin
                    if (r_paddr == r_pos) begin
                        n_out = i_rdata;
                    end else begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = r_paddr - 1'b1;
                        o_mem.wdata = i_rdata;
                    end
                end else if (!r_issue) begin
                    if (r_cmd == CMD_DELETE) begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_RSP;
                end
            end
            S_RSP: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_rsp_valid = (r_state == S_RSP);

    always_comb begin
        o_rsp.value_out = 32'(r_out);
        o_rsp.status    = r_status;
        o_rsp.count     = 7'(r_count);
        o_rsp.is_full   = (r_count == CW'(DEPTH));
        o_rsp.is_empty  = (r_count == '0);
    end

    `ILS_ASSERT_IMP(a_count_cap, 1'b1, r_count <= CW'(DEPTH), "count above capacity")
    `ILS_ASSERT_IMP(a_no_write_idle, (r_state == S_IDLE) || (r_state == S_RSP), !o_mem.we, "store write outside a command")
    `ILS_ASSERT_NXT(a_issue_pend, r_issue && ((r_state == S_INS) || (r_state == S_DEL)), r_pend, "issued read not followed")

endmodule

`default_nettype wire

/* rtl/core/indexed_list_store.sv */
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of up to DEPTH entries with positional insert and delete, plus
// retrieve, replace and clear.
// Usage:
//   Request channel: i_req_valid / o_req_stall / i_req (command, position,
//   value_in). A request is taken on a clock edge with valid high and stall
//   low. Stall is high from the edge after a request is taken until the
//   sequencer has handed its response to the output register.
//   Response channel: o_rsp_valid / i_rsp_stall / o_rsp. Exactly one response
//   per request, in order, holding value_out, status, count and the flags.
// Store traffic per command:
//   insert      : one store access per shifted entry through the single read
//                 and write port; an append moves nothing
//   delete      : reads the entry, then moves each later entry one slot down
//   retrieve    : one read; replace one write; clear and rejected requests
//                 touch no entry.
//   The longest command is a delete of the head of a full list.
// Reset: synchronous, active low; the list becomes empty. Entry storage is
//   not cleared; entries above the count are never read.
// Back-pressure: while the response register is full and stalled, one more
//   request may be taken and run; its response waits in the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_list_store_assert.svh"

module indexed_list_store import ils_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);

    t_mem_req         mem;
    logic [WIDTH-1:0] rdata;
    logic             busy;
    logic             seq_rsp_valid;
    t_rsp             seq_rsp;
    logic             rsp_ready;

    logic r_rsp_valid, n_rsp_valid;
    t_rsp r_rsp, n_rsp;

    // Entry storage: the shifts stream through its one read and one write port.
    ils_ram #(
        .W (WIDTH),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );

    ils_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_mem       (mem),
        .i_rdata     (rdata),
        .o_rsp_valid (seq_rsp_valid),
        .o_rsp       (seq_rsp),
        .i_rsp_ready (rsp_ready)
    );

    // Sequencer is ready only when idle.
    assign o_req_stall = busy;

    // Output register frees the sequencer as soon as the slot is open.
    assign rsp_ready = !r_rsp_valid || !i_rsp_stall;

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        if (rsp_ready) begin
            n_rsp_valid = seq_rsp_valid;
            if (seq_rsp_valid) begin
                n_rsp = seq_rsp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    `ILS_ASSERT_IMP(a_full_flag, o_rsp_valid && (o_rsp.status == ST_FULL), o_rsp.is_full, "full status without full flag")
    `ILS_ASSERT_IMP(a_empty_flag, o_rsp_valid, o_rsp.is_empty == (o_rsp.count == 7'd0), "empty flag disagrees with count")

endmodule

`default_nettype wire
